@@ rtl/spi_pkg.sv @@
// spi_pkg: shared widths and register indexes for the segment/plane tester
// no dependencies; used by segment_plane_intersect, spi_checker and the testbench
`default_nettype none
package spi_pkg;
  localparam int PT_W      = 32;
  localparam int NRM_W     = 18;
  localparam int TOL_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd4;
endpackage
`default_nettype wire

@@ rtl/segment_plane_intersect.sv @@
// segment_plane_intersect: pipelined segment vs plane test, one request per cycle
// the datapath is a one-bit-per-stage square root (33 stages) followed by three
// restoring divider chains
// throughput one request per clock, busy stays low; the receiver cannot stall
// synchronous active-low reset clears valid bits and loads register defaults
// depends on spi_pkg
`default_nettype none
module segment_plane_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire signed [spi_pkg::PT_W-1:0]     in_start_x,
  input  wire signed [spi_pkg::PT_W-1:0]     in_start_y,
  input  wire signed [spi_pkg::PT_W-1:0]     in_start_z,
  input  wire signed [spi_pkg::PT_W-1:0]     in_end_x,
  input  wire signed [spi_pkg::PT_W-1:0]     in_end_y,
  input  wire signed [spi_pkg::PT_W-1:0]     in_end_z,
  output logic                               out_strobe,
  output logic                               out_hit,
  output logic signed [spi_pkg::PT_W-1:0]    out_fraction,
  output logic                               out_degenerate,
  input  wire                                cfg_we,
  input  wire [spi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [spi_pkg::PT_W-1:0]            cfg_wdata
);
  localparam int PT_W   = spi_pkg::PT_W;
  localparam int NRM_W  = spi_pkg::NRM_W;
  localparam int TOL_W  = spi_pkg::TOL_W;
  localparam int D_W    = PT_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int NDP_W  = NRM_W + D_W;
  localparam int PSP_W  = NRM_W + PT_W;
  localparam int ND_W   = NDP_W + 2;
  localparam int PS_W   = PSP_W + 2;
  localparam int NUM_W  = (FRAC_BITS + 33 > 52) ? FRAC_BITS + 33 : 52;
  localparam int LEN_W  = 33;
  localparam int SQ_N   = LEN_W;
  localparam int SREM_W = LEN_W + 2;
  localparam int DQ_W   = 22;
  localparam int DREM_W = LEN_W + 1;
  localparam int NREM_W = DQ_W + 1;
  localparam int FQ_W   = 32;

  assign busy = 1'b0;

  // configuration registers
  logic signed [NRM_W-1:0] nx_r, ny_r, nz_r;
  logic signed [PT_W-1:0]  off_r;
  logic [TOL_W-1:0]        tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= NRM_W'(65536);
      off_r <= '0;
      tol_r <= TOL_W'(66);
    end else if (cfg_we) begin
      unique case (cfg_index)
        spi_pkg::REG_NORMAL_X:     nx_r  <= cfg_wdata[NRM_W-1:0];
        spi_pkg::REG_NORMAL_Y:     ny_r  <= cfg_wdata[NRM_W-1:0];
        spi_pkg::REG_NORMAL_Z:     nz_r  <= cfg_wdata[NRM_W-1:0];
        spi_pkg::REG_PLANE_OFFSET: off_r <= cfg_wdata;
        spi_pkg::REG_TOLERANCE:    tol_r <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a1: deltas
  logic                   a1_v_r;
  logic signed [PT_W-1:0] a1_s_r [0:2];
  logic signed [D_W-1:0]  a1_d_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) a1_v_r <= 1'b0;
    else        a1_v_r <= start;
    a1_s_r[0] <= in_start_x;
    a1_s_r[1] <= in_start_y;
    a1_s_r[2] <= in_start_z;
    a1_d_r[0] <= D_W'(in_end_x) - D_W'(in_start_x);
    a1_d_r[1] <= D_W'(in_end_y) - D_W'(in_start_y);
    a1_d_r[2] <= D_W'(in_end_z) - D_W'(in_start_z);
  end

  // stage a2: squares and normal products
  logic                    a2_v_r;
  logic [SQ_W-1:0]         a2_sq_r  [0:2];
  logic signed [NDP_W-1:0] a2_ndp_r [0:2];
  logic signed [PSP_W-1:0] a2_psp_r [0:2];
  logic [D_W-1:0]          a1_m     [0:2];
  logic signed [NRM_W-1:0] nrm      [0:2];

  assign nrm[0] = nx_r;
  assign nrm[1] = ny_r;
  assign nrm[2] = nz_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a1_m[i] = a1_d_r[i][D_W-1] ? D_W'(-a1_d_r[i]) : D_W'(a1_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a2_v_r <= 1'b0;
    else        a2_v_r <= a1_v_r;
    for (int i = 0; i < 3; i++) begin
      a2_sq_r[i]  <= SQ_W'(a1_m[i]) * SQ_W'(a1_m[i]);
      a2_ndp_r[i] <= NDP_W'(nrm[i]) * NDP_W'(a1_d_r[i]);
      a2_psp_r[i] <= PSP_W'(nrm[i]) * PSP_W'(a1_s_r[i]);
    end
  end

  // square root chain, entry holds the sums
  logic                    sq_v_r    [0:SQ_N];
  logic [SQ_W-1:0]         sq_rad_r  [0:SQ_N];
  logic [SREM_W-1:0]       sq_rem_r  [0:SQ_N];
  logic [LEN_W-1:0]        sq_root_r [0:SQ_N];
  logic signed [ND_W-1:0]  sq_nd_r   [0:SQ_N];
  logic signed [NUM_W-1:0] sq_num_r  [0:SQ_N];
  logic signed [PS_W-1:0]  ps_sum;
  logic signed [PT_W+FRAC_BITS-1:0] off_sh;

  assign ps_sum = PS_W'(a2_psp_r[0]) + PS_W'(a2_psp_r[1]) + PS_W'(a2_psp_r[2]);
  assign off_sh = {off_r, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else        sq_v_r[0] <= a2_v_r;
    sq_rad_r[0]  <= a2_sq_r[0] + a2_sq_r[1] + a2_sq_r[2];
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_nd_r[0]   <= ND_W'(a2_ndp_r[0]) + ND_W'(a2_ndp_r[1]) + ND_W'(a2_ndp_r[2]);
    sq_num_r[0]  <= NUM_W'(off_sh) - NUM_W'(ps_sum);
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SREM_W-1:0] rem_sh, trial;
    logic              ge;
    assign rem_sh = {sq_rem_r[k][SREM_W-3:0], sq_rad_r[k][SQ_W-1 -: 2]};
    assign trial  = {sq_root_r[k], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else        sq_v_r[k+1] <= sq_v_r[k];
      sq_rad_r[k+1]  <= {sq_rad_r[k][SQ_W-3:0], 2'b00};
      sq_rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
      sq_root_r[k+1] <= {sq_root_r[k][LEN_W-2:0], ge};
      sq_nd_r[k+1]   <= sq_nd_r[k];
      sq_num_r[k+1]  <= sq_num_r[k];
    end
  end

  // denominator: |nd| / len, quotient known to fit DQ_W bits
  logic                    d1_v_r   [0:DQ_W];
  logic [DREM_W-1:0]       d1_rem_r [0:DQ_W];
  logic [DQ_W-1:0]         d1_lo_r  [0:DQ_W];
  logic [DQ_W-1:0]         d1_q_r   [0:DQ_W];
  logic [LEN_W-1:0]        d1_len_r [0:DQ_W];
  logic                    d1_neg_r [0:DQ_W];
  logic signed [NUM_W-1:0] d1_num_r [0:DQ_W];
  logic [ND_W-1:0]         nd_mag;

  assign nd_mag = sq_nd_r[SQ_N][ND_W-1] ? ND_W'(-sq_nd_r[SQ_N]) : ND_W'(sq_nd_r[SQ_N]);

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[0] <= 1'b0;
    else        d1_v_r[0] <= sq_v_r[SQ_N];
    d1_rem_r[0] <= DREM_W'(nd_mag[ND_W-1:DQ_W]);
    d1_lo_r[0]  <= nd_mag[DQ_W-1:0];
    d1_q_r[0]   <= '0;
    d1_len_r[0] <= sq_root_r[SQ_N];
    d1_neg_r[0] <= sq_nd_r[SQ_N][ND_W-1];
    d1_num_r[0] <= sq_num_r[SQ_N];
  end

  for (genvar k = 0; k < DQ_W; k++) begin : g_div_den
    logic [DREM_W-1:0] rsh;
    logic              ge;
    assign rsh = {d1_rem_r[k][DREM_W-2:0], d1_lo_r[k][DQ_W-1]};
    assign ge  = rsh >= DREM_W'(d1_len_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) d1_v_r[k+1] <= 1'b0;
      else        d1_v_r[k+1] <= d1_v_r[k];
      d1_rem_r[k+1] <= ge ? rsh - DREM_W'(d1_len_r[k]) : rsh;
      d1_lo_r[k+1]  <= {d1_lo_r[k][DQ_W-2:0], 1'b0};
      d1_q_r[k+1]   <= {d1_q_r[k][DQ_W-2:0], ge};
      d1_len_r[k+1] <= d1_len_r[k];
      d1_neg_r[k+1] <= d1_neg_r[k];
      d1_num_r[k+1] <= d1_num_r[k];
    end
  end

  // distance: |num| / |denom|, full width quotient
  logic               d2_v_r     [0:NUM_W];
  logic [NREM_W-1:0]  d2_rem_r   [0:NUM_W];
  logic [NUM_W-1:0]   d2_lo_r    [0:NUM_W];
  logic [NUM_W-1:0]   d2_q_r     [0:NUM_W];
  logic [DQ_W-1:0]    d2_den_r   [0:NUM_W];
  logic [LEN_W-1:0]   d2_len_r   [0:NUM_W];
  logic               d2_big_r   [0:NUM_W];
  logic               d2_dz_r    [0:NUM_W];
  logic               d2_neg_r   [0:NUM_W];
  logic               d2_small_r [0:NUM_W];
  logic [NUM_W-1:0]   num_mag;
  logic [DQ_W-1:0]    den_q;
  logic signed [NUM_W-1:0] num_in;

  assign num_in  = d1_num_r[DQ_W];
  assign den_q   = d1_q_r[DQ_W];
  assign num_mag = num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r[0] <= 1'b0;
    else        d2_v_r[0] <= d1_v_r[DQ_W];
    d2_rem_r[0]   <= '0;
    d2_lo_r[0]    <= num_mag;
    d2_q_r[0]     <= '0;
    d2_den_r[0]   <= den_q;
    d2_len_r[0]   <= d1_len_r[DQ_W];
    d2_big_r[0]   <= den_q > DQ_W'(tol_r);
    d2_dz_r[0]    <= den_q == '0;
    d2_neg_r[0]   <= num_in[NUM_W-1] ^ d1_neg_r[DQ_W];
    d2_small_r[0] <= num_mag < {(NUM_W-FRAC_BITS)'(tol_r), {FRAC_BITS{1'b0}}};
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div_num
    logic [NREM_W-1:0] rsh;
    logic              ge;
    assign rsh = {d2_rem_r[k][NREM_W-2:0], d2_lo_r[k][NUM_W-1]};
    assign ge  = rsh >= NREM_W'(d2_den_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) d2_v_r[k+1] <= 1'b0;
      else        d2_v_r[k+1] <= d2_v_r[k];
      d2_rem_r[k+1]   <= ge ? rsh - NREM_W'(d2_den_r[k]) : rsh;
      d2_lo_r[k+1]    <= {d2_lo_r[k][NUM_W-2:0], 1'b0};
      d2_q_r[k+1]     <= {d2_q_r[k][NUM_W-2:0], ge};
      d2_den_r[k+1]   <= d2_den_r[k];
      d2_len_r[k+1]   <= d2_len_r[k];
      d2_big_r[k+1]   <= d2_big_r[k];
      d2_dz_r[k+1]    <= d2_dz_r[k];
      d2_neg_r[k+1]   <= d2_neg_r[k];
      d2_small_r[k+1] <= d2_small_r[k];
    end
  end

  // f1: pick the distance and decide the hit
  logic             f1_v_r, f1_neg_r, f1_hit_r;
  logic [NUM_W-1:0] f1_tmag_r;
  logic [LEN_W-1:0] f1_len_r;
  logic [NUM_W-1:0] tq;
  logic             use_tt, ok_f1, neg_f1;
  logic [NUM_W-1:0] tmag_f1;

  assign tq = d2_q_r[NUM_W];

  always_comb begin
    // near-parallel: keep the quotient only when it is inside the tolerance
    use_tt  = d2_big_r[NUM_W] || (!d2_dz_r[NUM_W] && tq < NUM_W'(tol_r));
    ok_f1   = use_tt || d2_small_r[NUM_W];
    tmag_f1 = use_tt ? tq : '0;
    neg_f1  = use_tt && d2_neg_r[NUM_W] && (tq != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f1_v_r <= 1'b0;
    else        f1_v_r <= d2_v_r[NUM_W];
    f1_tmag_r <= tmag_f1;
    f1_neg_r  <= neg_f1;
    f1_hit_r  <= ok_f1 && !neg_f1 && (tmag_f1 <= NUM_W'(d2_len_r[NUM_W]));
    f1_len_r  <= d2_len_r[NUM_W];
  end

  // fraction: (|t| << F) / len, flagged once the quotient passes 32 bits, saturated at 2^31
  logic              d3_v_r   [0:FQ_W];
  logic [DREM_W-1:0] d3_rem_r [0:FQ_W];
  logic [FQ_W-1:0]   d3_lo_r  [0:FQ_W];
  logic [FQ_W-1:0]   d3_q_r   [0:FQ_W];
  logic [LEN_W-1:0]  d3_len_r [0:FQ_W];
  logic              d3_ovf_r [0:FQ_W];
  logic              d3_neg_r [0:FQ_W];
  logic              d3_hit_r [0:FQ_W];
  logic [NUM_W-1:0]  t_hi;

  assign t_hi = f1_tmag_r >> (FQ_W - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) d3_v_r[0] <= 1'b0;
    else        d3_v_r[0] <= f1_v_r;
    d3_rem_r[0] <= t_hi[DREM_W-1:0];
    d3_lo_r[0]  <= {f1_tmag_r[FQ_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    d3_q_r[0]   <= '0;
    d3_len_r[0] <= f1_len_r;
    d3_ovf_r[0] <= t_hi >= NUM_W'(f1_len_r);
    d3_neg_r[0] <= f1_neg_r;
    d3_hit_r[0] <= f1_hit_r;
  end

  for (genvar k = 0; k < FQ_W; k++) begin : g_div_frac
    logic [DREM_W-1:0] rsh;
    logic              ge;
    assign rsh = {d3_rem_r[k][DREM_W-2:0], d3_lo_r[k][FQ_W-1]};
    assign ge  = rsh >= DREM_W'(d3_len_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) d3_v_r[k+1] <= 1'b0;
      else        d3_v_r[k+1] <= d3_v_r[k];
      d3_rem_r[k+1] <= ge ? rsh - DREM_W'(d3_len_r[k]) : rsh;
      d3_lo_r[k+1]  <= {d3_lo_r[k][FQ_W-2:0], 1'b0};
      d3_q_r[k+1]   <= {d3_q_r[k][FQ_W-2:0], ge};
      d3_len_r[k+1] <= d3_len_r[k];
      d3_ovf_r[k+1] <= d3_ovf_r[k];
      d3_neg_r[k+1] <= d3_neg_r[k];
      d3_hit_r[k+1] <= d3_hit_r[k];
    end
  end

  // output register
  logic [FQ_W:0]   fm;
  logic [FQ_W:0]   cap;
  logic [PT_W-1:0] frac_nxt;
  logic            degen;

  assign cap   = (FQ_W+1)'(1) << (FQ_W - 1);
  assign degen = d3_len_r[FQ_W] == '0;

  always_comb begin
    fm = (d3_ovf_r[FQ_W] || ({1'b0, d3_q_r[FQ_W]} > cap)) ? cap : {1'b0, d3_q_r[FQ_W]};
    if (degen) begin
      frac_nxt = '0;
    end else if (d3_neg_r[FQ_W]) begin
      frac_nxt = PT_W'(-fm);
    end else if (fm > (cap - 1'b1)) begin
      frac_nxt = PT_W'(cap - 1'b1);
    end else begin
      frac_nxt = PT_W'(fm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= d3_v_r[FQ_W];
    out_hit        <= d3_hit_r[FQ_W] && !degen;
    out_fraction   <= frac_nxt;
    out_degenerate <= degen;
  end
endmodule
`default_nettype wire

@@ rtl/spi_checker.sv @@
// spi_checker: port-level assertions for segment_plane_intersect, bound to the top
// depends on spi_pkg
`default_nettype none
module spi_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            busy,
  input wire                            out_strobe,
  input wire                            out_hit,
  input wire [spi_pkg::PT_W-1:0]        out_fraction,
  input wire                            out_degenerate
);
  localparam logic [spi_pkg::PT_W-1:0] ONE = spi_pkg::PT_W'(1) << FRAC_BITS;

  // pipeline takes a request every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_degenerate |-> !out_hit && out_fraction == '0)
    else $error("degenerate result carries a hit or fraction");

  // a hit lies within the segment so the fraction is in 0..1
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_hit |-> !out_fraction[spi_pkg::PT_W-1] && out_fraction <= ONE)
    else $error("hit with fraction outside 0..1");
endmodule

bind segment_plane_intersect spi_checker #(.FRAC_BITS(FRAC_BITS)) u_spi_checker (.*);
`default_nettype wire

@@ tb/tb_segment_plane_intersect.sv @@
// tb_segment_plane_intersect: self-checking bench for the segment/plane tester
// drives requests and plane settings, predicts each result, checks it on out_strobe
// depends on spi_pkg and segment_plane_intersect
`default_nettype none
module tb_segment_plane_intersect;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] fraction;
    logic               degenerate;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [spi_pkg::PT_W-1:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [spi_pkg::PT_W-1:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_strobe, out_hit, out_degenerate;
  logic signed [spi_pkg::PT_W-1:0] out_fraction;
  logic cfg_we = 1'b0;
  logic [spi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spi_pkg::PT_W-1:0] cfg_wdata = '0;

  // plane settings as the block should hold them
  logic signed [spi_pkg::NRM_W-1:0] nrm_x = '0, nrm_y = '0, nrm_z = 18'sd65536;
  logic signed [31:0]               plane_off = '0;
  logic [spi_pkg::TOL_W-1:0]        plane_tol = 16'd66;
  int unsigned                      plane_axis = 2;

  crossing_t crossing_q[$];
  int unsigned accept_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_pct = 0;

  segment_plane_intersect DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .out_strobe(out_strobe), .out_hit(out_hit), .out_fraction(out_fraction),
    .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
  endfunction

  function automatic crossing_t predict_crossing(input logic signed [31:0] p[6]);
    longint s[3], d[3], n[3];
    logic [127:0] sumsq;
    longint unsigned m, len, c, a, q, r, fm, tol;
    longint nd, ps, num, denom, t, tt;
    bit ok;
    crossing_t res;
    n[0] = longint'(nrm_x);
    n[1] = longint'(nrm_y);
    n[2] = longint'(nrm_z);
    sumsq = '0;
    nd = 0;
    ps = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'(p[i]);
      d[i] = longint'(p[i+3]) - s[i];
      m = mag(d[i]);
      sumsq += 128'(m) * 128'(m);
      nd += n[i] * d[i];
      ps += n[i] * s[i];
    end
    len = 0;
    for (int b = 34; b >= 0; b--) begin
      c = len | (64'd1 << b);
      if (128'(c) * 128'(c) <= sumsq) len = c;
    end
    res = '0;
    if (len == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    tol = 64'(plane_tol);
    num = longint'(plane_off) * 65536 - ps;
    denom = nd / longint'(len);
    ok = 1'b0;
    t = 0;
    if (mag(denom) > tol) begin
      t = num / denom;
      ok = 1'b1;
    end else begin
      if (denom != 0) begin
        tt = num / denom;
        if (mag(tt) < tol) begin
          t = tt;
          ok = 1'b1;
        end
      end
      if (!ok) begin
        t = 0;
        ok = mag(num) < (tol << 16);
      end
    end
    res.hit = ok && t >= 0 && t <= longint'(len);
    a = mag(t);
    q = a / len;
    r = a % len;
    if (q > 64'd32768) fm = 64'd1 << 31;
    else begin
      fm = (q << 16) + ((r << 16) / len);
      if (fm > (64'd1 << 31)) fm = 64'd1 << 31;
    end
    if (t < 0) res.fraction = 32'(64'd0 - fm);
    else res.fraction = (fm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : fm[31:0];
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // request capture and result checking on the pre-edge values
  always @(posedge clk) begin
    logic signed [31:0] p[6];
    crossing_t want;
    if (rst_n && start && !busy) begin
      p = '{in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z};
      crossing_q.push_back(predict_crossing(p));
      accept_cnt++;
    end
    if (rst_n && out_strobe) begin
      if (crossing_q.size() == 0) report("unexpected result", 1, 0);
      else begin
        want = crossing_q.pop_front();
        if (out_hit !== want.hit) report("hit", out_hit, want.hit);
        if (out_fraction !== want.fraction) report("fraction", out_fraction, want.fraction);
        if (out_degenerate !== want.degenerate)
          report("degenerate", out_degenerate, want.degenerate);
      end
    end
  end

  task automatic send_segment(input logic signed [31:0] sx, sy, sz, ex, ey, ez);
    int unsigned n0;
    // each cycle is idle with the phase's probability
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_start_z <= sz;
    in_end_x <= ex; in_end_y <= ey; in_end_z <= ez;
    n0 = accept_cnt;
    @(posedge clk);
    wait (accept_cnt != n0);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    wait (crossing_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [spi_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      spi_pkg::REG_NORMAL_X:     nrm_x = val[spi_pkg::NRM_W-1:0];
      spi_pkg::REG_NORMAL_Y:     nrm_y = val[spi_pkg::NRM_W-1:0];
      spi_pkg::REG_NORMAL_Z:     nrm_z = val[spi_pkg::NRM_W-1:0];
      spi_pkg::REG_PLANE_OFFSET: plane_off = val;
      spi_pkg::REG_TOLERANCE:    plane_tol = val[spi_pkg::TOL_W-1:0];
      default: ;
    endcase
  endtask

  // junk in the high bits must be dropped, unknown indexes ignored
  task automatic set_plane(input int nx, ny, nz, input logic [31:0] off,
                           input logic [15:0] tol, input int unsigned axis);
    cfg_write(spi_pkg::REG_NORMAL_X, {14'($urandom_range(16383)), 18'(nx)});
    cfg_write(spi_pkg::REG_NORMAL_Y, {14'($urandom_range(16383)), 18'(ny)});
    cfg_write(spi_pkg::REG_NORMAL_Z, {14'($urandom_range(16383)), 18'(nz)});
    cfg_write(spi_pkg::REG_PLANE_OFFSET, off);
    cfg_write(spi_pkg::REG_TOLERANCE, {16'($urandom), tol});
    cfg_write(3'($urandom_range(5, 7)), $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    plane_axis = axis;
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  task automatic test_directed;
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    // reset plane is z = 0
    send_segment(0, 0, -65536, 0, 0, 65536);
    send_segment(0, 0, 0, 0, 0, 65536);
    send_segment(0, 0, -65536, 0, 0, 0);
    send_segment(0, 0, 65536, 0, 0, 131072);
    send_segment(0, 0, -131072, 0, 0, -65536);
    send_segment(5, 5, 5, 5, 5, 5);
    send_segment(mx, mx, mx, mx, mx, mx);
    send_segment(0, 0, 0, 65536, 0, 0);
    send_segment(0, 0, 100, 65536, 0, 100);
    send_segment(0, 0, 3, 65536 * 16, 0, 40);
    send_segment(mn, mn, mn, mx, mx, mx);
    send_segment(mx, mn, mx, mn, mx, mn);
    send_segment(0, 0, mn, 0, 0, mx);
    send_segment(0, 0, 1, 0, 0, 2);
    send_segment(0, 0, -1, 0, 0, mx);
    drain();
    set_plane(-65536, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_segment(mx, 0, 0, mn, 0, 0);
    send_segment(0, 0, 0, 0, 65536, 0);
    send_segment(mx - 65536, 0, 0, mx - 65536, 1 << 20, 0);
    drain();
    set_plane(0, 65536, 0, 32'sh8000_0000, 16'h0000, 1);
    send_segment(0, mn, 0, 0, mx, 0);
    send_segment(0, mn, 0, 65536, mn, 0);
    send_segment(0, mn + 1, 0, 65536, mn + 1, 0);
    send_segment(0, 0, 0, 0, 1, 0);
    drain();
  endtask

  task automatic test_random(input int unsigned count);
    logic signed [31:0] p[6];
    int unsigned kind;
    for (int unsigned k = 0; k < count; k++) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        for (int i = 0; i < 6; i++) p[i] = $urandom;
      end else begin
        for (int i = 0; i < 6; i++) p[i] = near_coord();
        if (kind < 30) p[plane_axis + 3] = p[plane_axis] + $signed($urandom_range(0, 8)) - 4;
        else if (kind < 35) for (int i = 0; i < 3; i++) p[i+3] = p[i];
      end
      send_segment(p[0], p[1], p[2], p[3], p[4], p[5]);
    end
    drain();
  endtask

  task automatic random_plane;
    int unsigned axis;
    int nv[3];
    axis = $urandom_range(2);
    nv = '{0, 0, 0};
    case ($urandom_range(3))
      0: nv[axis] = ($urandom_range(1)) ? 65536 : -65536;
      1: begin
        nv[axis] = 46341;
        nv[(axis + 1) % 3] = ($urandom_range(1)) ? 46341 : -46341;
      end
      2: begin
        nv[axis] = 37837; nv[(axis + 1) % 3] = -37837; nv[(axis + 2) % 3] = 37837;
      end
      default: for (int i = 0; i < 3; i++) nv[i] = int'($urandom_range(0, 131072)) - 65536;
    endcase
    set_plane(nv[0], nv[1], nv[2], near_coord(), 16'($urandom_range(0, 3000)), axis);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_pct = 0;
    set_plane(0, 0, 65536, 0, 16'd66, 2);
    test_random(250);
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 62 : 36;
      if (ph == 4) set_plane(0, -65536, 0, near_coord(), 16'hFFFF, 1);
      else if (ph == 5) set_plane(65536, 0, 0, near_coord(), 16'h0000, 0);
      else random_plane();
      test_random(250);
    end
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(12 * 1_000_000);
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
